@@ src/sspq_pkg.sv @@
// ----------------------------------------------------------------------------
// sspq_pkg
// Types and constants shared by the stable sorted priority queue modules.
// ----------------------------------------------------------------------------
package sspq_pkg;

    // Queue size, field widths and the occupancy width that follows from the size
    localparam int QUEUE_DEPTH = 16;
    localparam int PRIO_BITS   = 8;
    localparam int TAG_BITS    = 16;
    localparam int OCC_BITS    = $clog2(QUEUE_DEPTH + 1);

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // One stored entry
    typedef struct packed {
        logic [PRIO_BITS-1:0] prio;
        logic [TAG_BITS-1:0]  tag;
    } slot_t;

    // Input request
    typedef struct packed {
        logic                 op;
        logic [PRIO_BITS-1:0] prio;
        logic [TAG_BITS-1:0]  tag;
    } req_t;

    // Result
    typedef struct packed {
        logic                 head_valid;
        logic [PRIO_BITS-1:0] head_prio;
        logic [TAG_BITS-1:0]  head_tag;
        logic [OCC_BITS-1:0]  occupancy;
        logic                 refused;
    } rsp_t;

    // Broadcast control for every cell of the chain
    typedef struct packed {
        logic  push;
        logic  pop;
        slot_t new_slot;
    } cell_ctrl_t;

endpackage

@@ src/stable_sorted_priority_queue_top.sv @@
// Stable sorted priority queue, built as a chain of slot cells.
// Output: the result of a request is in the output register in the cycle
// after the request is accepted. Throughput: one request per cycle while the
// output is not stalled; each cell compares against the new priority in
// parallel and shifts at most one position, in the same cycle.
// Reset: synchronous, active low; the queue empties and no result is pending.
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_top
// Push keeps descending priority order with FIFO order among equal
// priorities; pop removes the head. One result per request.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_top (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  sspq_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output sspq_pkg::rsp_t  m_data
);
    import sspq_pkg::*;

    localparam int CNT_W = OCC_BITS;

    slot_t                slot_q    [QUEUE_DEPTH];
    slot_t                slot_n    [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] used_q;
    logic [QUEUE_DEPTH-1:0] used_n;
    logic [QUEUE_DEPTH-1:0] ins_vec;

    cell_ctrl_t           ctrl;
    logic                 accept;
    logic                 full;
    logic                 empty;
    logic                 refused;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    rsp_t                 rsp;
    rsp_t                 m_data_reg;
    logic                 m_valid_reg;

    assign full   = used_q[QUEUE_DEPTH-1];
    assign empty  = !used_q[0];
    assign s_ready = !m_valid_reg || m_ready;
    assign accept = s_valid && s_ready;

    // Gate the operation: drop a push when full, ignore a pop when empty
    always_comb begin
        ctrl.push          = accept && (s_data.op == OP_PUSH) && !full;
        ctrl.pop           = accept && (s_data.op == OP_POP) && !empty;
        ctrl.new_slot.prio = s_data.prio;
        ctrl.new_slot.tag  = s_data.tag;
        refused = (s_data.op == OP_PUSH) ? full : empty;
    end

    // Build the cell chain
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        slot_t prev_slot;
        logic  prev_used;
        logic  prev_ins;
        slot_t next_slot;
        logic  next_used;

        if (i == 0) begin : g_first
            assign prev_slot = ctrl.new_slot;
            assign prev_used = 1'b1;
            assign prev_ins  = 1'b0;
        end else begin : g_inner_prev
            assign prev_slot = slot_q[i-1];
            assign prev_used = used_q[i-1];
            assign prev_ins  = ins_vec[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign next_slot = '0;
            assign next_used = 1'b0;
        end else begin : g_inner_next
            assign next_slot = slot_q[i+1];
            assign next_used = used_q[i+1];
        end

        sspq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .prev_slot   (prev_slot),
            .prev_used   (prev_used),
            .prev_ins    (prev_ins),
            .next_slot   (next_slot),
            .next_used   (next_used),
            .slot        (slot_q[i]),
            .slot_next_o (slot_n[i]),
            .used        (used_q[i]),
            .used_next_o (used_n[i]),
            .ins         (ins_vec[i])
        );
    end

    // Advance the entry count
    always_comb begin
        cnt_next = cnt_reg;
        if (ctrl.push) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (ctrl.pop) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Form the result from the post-operation head
    always_comb begin
        rsp.head_valid = used_n[0];
        rsp.head_prio  = used_n[0] ? slot_n[0].prio : '0;
        rsp.head_tag   = used_n[0] ? slot_n[0].tag : '0;
        rsp.occupancy  = cnt_next;
        rsp.refused    = refused;
    end

    // Hold count and output register
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= rsp;
        end
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // Used bits are exactly the count
    a_used_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(used_q) == int'(cnt_reg))
        else $error("used bits disagree with entry count");

    // Head is never below the second entry
    a_head_order: assert property (@(posedge aclk) disable iff (!aresetn)
        used_q[1] |-> (slot_q[0].prio >= slot_q[1].prio))
        else $error("queue head out of order");

    // A push into a full queue is refused and leaves the count alone
    a_full_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.op == OP_PUSH) && full)
        |=> (m_data_reg.refused && $stable(cnt_reg)))
        else $error("push into full queue not refused");

    // A pop on a nonempty queue drops the count by one
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.op == OP_POP) && !empty)
        |=> (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("pop did not reduce count");
`endif

endmodule

@@ src/sspq_cell.sv @@
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted chain: holds an entry and a used bit, shifts toward
// the tail on an insert ahead of it and toward the head on a pop.
// ----------------------------------------------------------------------------
module sspq_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  sspq_pkg::cell_ctrl_t ctrl,
    input  sspq_pkg::slot_t     prev_slot,
    input  logic                prev_used,
    input  logic                prev_ins,
    input  sspq_pkg::slot_t     next_slot,
    input  logic                next_used,
    output sspq_pkg::slot_t     slot,
    output sspq_pkg::slot_t     slot_next_o,
    output logic                used,
    output logic                used_next_o,
    output logic                ins
);
    import sspq_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;
    logic  used_reg;
    logic  used_next;

    // The new entry belongs here or above when this slot is free or lower
    assign ins = !used_reg || (slot_reg.prio < ctrl.new_slot.prio);

    // Select the next slot contents
    always_comb begin
        slot_next = slot_reg;
        used_next = used_reg;
        if (ctrl.push) begin
            used_next = used_reg | prev_used;
            if (ins) begin
                slot_next = prev_ins ? prev_slot : ctrl.new_slot;
            end
        end else if (ctrl.pop) begin
            slot_next = next_slot;
            used_next = next_used;
        end
    end

    // Hold payload, reset the used bit
    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else begin
            used_reg <= used_next;
        end
    end

    assign slot        = slot_reg;
    assign slot_next_o = slot_next;
    assign used        = used_reg;
    assign used_next_o = used_next;

endmodule

@@ test/stable_sorted_priority_queue_top_test.sv @@
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_top_test
// Self-checking bench for the sorted priority queue. A scoreboard keeps its
// own sorted copy of the queue, works out the head, count and refusal for
// every accepted request, and compares each result field by field. Requests
// arrive in random bursts while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sspq_pkg::*;

    localparam int RANDOM_ITEMS = 1330;
    localparam int HOLD_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 200000;

    // ------------------------------------------------------------------------
    // Scoreboard: sorted shadow queue and the results it predicts
    // ------------------------------------------------------------------------
    class sspq_scoreboard;
        slot_t       shadow_q[$];
        rsp_t        head_reports[$];
        int unsigned errors;
        int unsigned n_push;
        int unsigned n_pop;
        int unsigned n_full_drop;
        int unsigned n_empty_pop;
        int unsigned peak_occ;

        function new();
            errors      = 0;
            n_push      = 0;
            n_pop       = 0;
            n_full_drop = 0;
            n_empty_pop = 0;
            peak_occ    = 0;
        endfunction

        function int unsigned pending();
            return head_reports.size();
        endfunction

        // Apply one accepted request to the shadow queue and note its result
        function void note_request(req_t r);
            rsp_t  e;
            slot_t s;
            int    pos;
            bit    was_refused;
            was_refused = 1'b0;
            if (r.op == OP_PUSH) begin
                n_push++;
                if (shadow_q.size() >= QUEUE_DEPTH) begin
                    was_refused = 1'b1;
                    n_full_drop++;
                end else begin
                    // Insert ahead of the first entry of lower priority
                    pos = shadow_q.size();
                    for (int i = 0; i < shadow_q.size(); i++) begin
                        if (shadow_q[i].prio < r.prio) begin
                            pos = i;
                            break;
                        end
                    end
                    s.prio = r.prio;
                    s.tag  = r.tag;
                    shadow_q.insert(pos, s);
                end
            end else begin
                n_pop++;
                if (shadow_q.size() == 0) begin
                    was_refused = 1'b1;
                    n_empty_pop++;
                end else begin
                    shadow_q.delete(0);
                end
            end
            if (shadow_q.size() > peak_occ)
                peak_occ = shadow_q.size();
            e = '0;
            if (shadow_q.size() > 0) begin
                e.head_valid = 1'b1;
                e.head_prio  = shadow_q[0].prio;
                e.head_tag   = shadow_q[0].tag;
            end
            e.occupancy = OCC_BITS'(shadow_q.size());
            e.refused   = was_refused;
            head_reports.insert(head_reports.size(), e);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(rsp_t got);
            rsp_t e;
            if (head_reports.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual %h",
                         $time, got);
                return;
            end
            e = head_reports[0];
            head_reports.delete(0);
            compare_field("head_valid", e.head_valid, got.head_valid);
            compare_field("head_prio", e.head_prio, got.head_prio);
            compare_field("head_tag", e.head_tag, got.head_tag);
            compare_field("occupancy", e.occupancy, got.occupancy);
            compare_field("refused", e.refused, got.refused);
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    sspq_scoreboard sb;
    bit             hold_req   = 1'b0;
    int unsigned    cycle_count = 0;

    stable_sorted_priority_queue_top i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #5 aclk = ~aclk;

    // Abort a run that stops making progress
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("stable_sorted_priority_queue_top_test: FAIL");
            $finish;
        end
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    function automatic req_t make_req(logic op, logic [PRIO_BITS-1:0] prio,
                                      logic [TAG_BITS-1:0] tag);
        req_t r;
        r.op   = op;
        r.prio = prio;
        r.tag  = tag;
        return r;
    endfunction

    // Random request; priorities often crowd together to force ties
    function automatic req_t random_req(int unsigned push_pct);
        req_t r;
        r.op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
        case ($urandom_range(3))
            0: r.prio = PRIO_BITS'($urandom_range(255));
            1: r.prio = PRIO_BITS'($urandom_range(3));
            2: r.prio = $urandom_range(1) ? 8'hFF : 8'h00;
            default: r.prio = PRIO_BITS'(8'h40 + $urandom_range(7));
        endcase
        r.tag = TAG_BITS'($urandom_range(16'hFFFF));
        return r;
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_request(req_t r);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_request(r);
    endtask

    task automatic idle_sender(int unsigned n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // Receiver: stall pattern in changing modes, plus a long hold-off on demand
    initial begin
        int unsigned mode;
        int unsigned mode_left;
        int unsigned tick;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(3);
                    mode_left = $urandom_range(200, 20);
                end
                mode_left--;
                tick++;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= $urandom_range(1);
                    2: m_ready <= ($urandom_range(3) == 0);
                    default: m_ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // Stimulus
    initial begin
        int unsigned sent;
        int unsigned burst;
        int unsigned push_pct;
        int unsigned pct_sel;
        bit          hold_done;
        bit          drain_done;
        sb = new();

        // Hold reset, then release it
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty pops, extremes, ties, fill to full and overflow
        send_request(make_req(OP_POP, 8'h00, 16'h0000));
        send_request(make_req(OP_POP, 8'hFF, 16'hFFFF));
        send_request(make_req(OP_PUSH, 8'h00, 16'h0000));
        send_request(make_req(OP_PUSH, 8'hFF, 16'hFFFF));
        send_request(make_req(OP_PUSH, 8'h80, 16'h0001));
        send_request(make_req(OP_PUSH, 8'h80, 16'h0002));
        send_request(make_req(OP_PUSH, 8'h80, 16'h0003));
        send_request(make_req(OP_PUSH, 8'hFF, 16'h1234));
        send_request(make_req(OP_PUSH, 8'h00, 16'hAAAA));
        for (int i = 0; i < 9; i++)
            send_request(make_req(OP_PUSH, PRIO_BITS'(i * 30), TAG_BITS'(16'h5000 + i)));
        send_request(make_req(OP_PUSH, 8'hFF, 16'hFFFF));
        send_request(make_req(OP_PUSH, 8'h00, 16'h0000));
        send_request(make_req(OP_POP, 8'hA5, 16'h5A5A));
        send_request(make_req(OP_POP, 8'h00, 16'h0000));
        send_request(make_req(OP_POP, 8'hFF, 16'hFFFF));

        // Random bursts; the push bias drifts so the queue sweeps full and empty
        sent       = 0;
        push_pct   = 50;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 100 < 30) begin
                pct_sel = $urandom_range(4);
                case (pct_sel)
                    0: push_pct = 85;
                    1: push_pct = 15;
                    2: push_pct = 65;
                    3: push_pct = 35;
                    default: push_pct = 50;
                endcase
            end

            // Hold the receiver off while requests keep coming
            if (!hold_done && sent >= 400) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
                repeat (40) begin
                    send_request(random_req(70));
                    sent++;
                end
            end

            // Pause the sender until every result is in
            if (!drain_done && sent >= 800) begin
                drain_done = 1'b1;
                idle_sender(1);
                wait_drained();
            end

            burst = $urandom_range(30, 1);
            repeat (burst) begin
                send_request(random_req(push_pct));
                sent++;
            end
            if ($urandom_range(3) != 0)
                idle_sender($urandom_range(8, 1));
        end

        // Drain and let the output register settle
        idle_sender(1);
        wait_drained();
        repeat (4) @(posedge aclk);

        $display("covered %0d pushes and %0d pops, %0d dropped on full, %0d refused on empty",
                 sb.n_push, sb.n_pop, sb.n_full_drop, sb.n_empty_pop);
        $display("peak occupancy %0d of %0d, %0d mismatches", sb.peak_occ, QUEUE_DEPTH,
                 sb.errors);
        if (sb.errors == 0) begin
            $display("stable_sorted_priority_queue_top_test: PASS");
        end else begin
            $display("stable_sorted_priority_queue_top_test: FAIL");
        end
        $finish;
    end

endmodule
